// ===== src/pla_pkg.sv =====
package pla_pkg;

  localparam int MaxLights = 16;
  localparam int IdxW = $clog2(MaxLights);
  localparam int CntW = $clog2(MaxLights + 1);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  z;
    logic [7:0]  level;
    logic [7:0]  color;
  } lamp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic go;
    logic init;
  } shade_req_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_QUERY = 2'd2
  } status_t;

  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_AMBIENT = 3'd1;
  localparam logic [2:0] REG_RED     = 3'd2;
  localparam logic [2:0] REG_GREEN   = 3'd3;
  localparam logic [2:0] REG_BLUE    = 3'd4;

  localparam logic [7:0]  ColorPlain = 8'd215;
  localparam logic [16:0] BlendScale = 17'd65280;

  function automatic logic [23:0] pal_rgb(input logic [7:0] color);
    logic [23:0] rgb;
    case (color)
      8'd206:  rgb = 24'hFFFF00;
      8'd207:  rgb = 24'hFF8000;
      8'd208:  rgb = 24'hFF0000;
      8'd209:  rgb = 24'h8000FF;
      8'd210:  rgb = 24'h0000FF;
      8'd211:  rgb = 24'h00FFFF;
      8'd212:  rgb = 24'h00FF00;
      8'd214:  rgb = 24'h808080;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ===== src/pla_cell.sv =====
module pla_cell (
  input  logic                clk,
  input  pla_pkg::cell_ctrl_t ctrl,
  input  pla_pkg::lamp_t      neighbor,
  input  pla_pkg::lamp_t      new_lamp,
  input  logic [15:0]         px,
  input  logic [15:0]         py,
  input  logic [3:0]          pz,
  output pla_pkg::lamp_t      lamp,
  output logic                hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lamp <= new_lamp;
    end else if (ctrl.shift) begin
      lamp <= neighbor;
    end
  end

  assign hit = (lamp.x == px) && (lamp.y == py) && (lamp.z == pz);

endmodule

// ===== src/pla_shade.sv =====
module pla_shade (
  input  logic                clk,
  input  logic                rst,
  input  pla_pkg::shade_req_t req,
  input  logic [7:0]          base_r,
  input  logic [7:0]          base_g,
  input  logic [7:0]          base_b,
  input  pla_pkg::lamp_t      head,
  input  logic [15:0]         qx,
  input  logic [15:0]         qy,
  input  logic [3:0]          qz,
  output logic                ack,
  output logic [20:0]         dyn,
  output logic [7:0]          r,
  output logic [7:0]          g,
  output logic [7:0]          b
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MIX  = 5'b01000,
    S_FIX  = 5'b10000
  } sstate_t;

  sstate_t     state;
  logic [31:0] sx, sy;
  logic [7:0]  sz;
  logic [33:0] den;
  logic [19:0] num;
  logic [19:0] rem;
  logic [19:0] quo;
  logic [4:0]  div_cnt;
  logic [7:0]  color;
  logic        blend;
  logic [15:0] mr, mg, mb;

  logic [15:0] dx, dy;
  logic [3:0]  dz;
  logic [20:0] rem_sh;
  logic        ge;
  logic [15:0] c;
  logic [16:0] w;
  logic [23:0] pal;

  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [24:0] t;
    logic [7:0]  q0;
    logic [15:0] rr;
    t  = {1'b0, m, 8'd0} + {9'd0, m};
    q0 = t[23:16];
    rr = m - ({q0, 8'd0} - {8'd0, q0});
    return (rr >= 16'd255) ? q0 + 8'd1 : q0;
  endfunction

  assign dx = (head.x > qx) ? head.x - qx : qx - head.x;
  assign dy = (head.y > qy) ? head.y - qy : qy - head.y;
  assign dz = (head.z > qz) ? head.z - qz : qz - head.z;

  assign rem_sh = {rem, num[19]};
  assign ge     = {13'd0, rem_sh} >= den;
  assign c      = quo[15:0];
  assign w      = pla_pkg::BlendScale - {1'b0, c};
  assign pal    = pla_pkg::pal_rgb(color);
  assign ack    = (state == S_FIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.go) begin
            state <= S_SUM;
          end
        end
        S_SUM:   state <= S_DIV;
        S_DIV: begin
          if (div_cnt == 5'd19) begin
            state <= S_MIX;
          end
        end
        S_MIX:   state <= S_FIX;
        S_FIX:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.init) begin
          r   <= base_r;
          g   <= base_g;
          b   <= base_b;
          dyn <= '0;
        end
        sx    <= dx * dx;
        sy    <= dy * dy;
        sz    <= {4'd0, dz} * {4'd0, dz};
        color <= head.color;
        num   <= {1'b0, head.level, 11'd0} + {3'b0, head.level, 9'd0};
      end
      S_SUM: begin
        den     <= {2'd0, sx} + {2'd0, sy} + {26'd0, sz} + 34'd10;
        rem     <= '0;
        quo     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= ge ? 20'(({13'd0, rem_sh}) - den) : rem_sh[19:0];
        quo     <= {quo[18:0], ge};
        num     <= {num[18:0], 1'b0};
        div_cnt <= div_cnt + 5'd1;
      end
      S_MIX: begin
        blend <= (quo > 20'd256) && (color != pla_pkg::ColorPlain);
        if (quo > 20'd256) begin
          dyn <= dyn + {5'd0, c};
        end
        mr <= 16'((({18'd0, r} * {9'd0, w}) + ({18'd0, pal[23:16]} * {10'd0, c})) >> 8);
        mg <= 16'((({18'd0, g} * {9'd0, w}) + ({18'd0, pal[15:8]} * {10'd0, c})) >> 8);
        mb <= 16'((({18'd0, b} * {9'd0, w}) + ({18'd0, pal[7:0]} * {10'd0, c})) >> 8);
      end
      S_FIX: begin
        if (blend) begin
          r <= div255(mr);
          g <= div255(mg);
          b <= div255(mb);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/point_light_accumulator_core.sv =====
// Add, remove and clear update the table directly; done pulses the cycle after the request.
// A query with lighting disabled answers in the same way.
// A lit query rotates the table once through the shading unit, whose 20-step divider runs
// for each stored light while empty slots pass straight through; busy is high meanwhile.
// Results are registered when done pulses and hold until the next accepted request; no stall.
// Synchronous active-high reset empties the table and loads the register defaults.
module point_light_accumulator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [3:0]  pos_z,
  input  logic [7:0]  light_level,
  input  logic [7:0]  light_color_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  total_light,
  output logic [7:0]  ambient_part,
  output logic [7:0]  dynamic_part,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                         state;
  logic [pla_pkg::CntW-1:0]       cnt;
  logic [pla_pkg::CntW-1:0]       idx;
  logic                           pend;
  logic                           lighting_enabled;
  logic [7:0]                     ambient_level, global_red, global_green, global_blue;
  logic [15:0]                    qx, qy;
  logic [3:0]                     qz;

  pla_pkg::lamp_t                 lamps [pla_pkg::MaxLights];
  pla_pkg::cell_ctrl_t            ctrl  [pla_pkg::MaxLights];
  logic [pla_pkg::MaxLights-1:0]  hit;
  logic [pla_pkg::MaxLights-1:0]  hit_upto;
  pla_pkg::lamp_t                 new_lamp;
  pla_pkg::shade_req_t            sreq;
  logic                           sack;
  logic [20:0]                    dyn;
  logic [7:0]                     sr, sg, sb;

  logic                           acc, is_add, is_rem, any_hit, add_ok, present, rotate;
  logic [pla_pkg::CntW-1:0]       cnt2;
  logic [12:0]                    dint;
  logic [21:0]                    tot;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign acc       = start && !busy;
  assign is_add    = acc && (op == pla_pkg::OP_ADD);
  assign is_rem    = acc && (op == pla_pkg::OP_REMOVE);
  assign present   = idx < cnt;
  assign rotate    = (state == ST_RUN) && (!present || sack);

  assign new_lamp = '{x: pos_x, y: pos_y, z: pos_z, level: light_level,
                      color: light_color_index};

  always_comb begin
    hit_upto[0] = hit[0] && (cnt > pla_pkg::CntW'(0));
    for (int i = 1; i < pla_pkg::MaxLights; i++) begin
      hit_upto[i] = hit_upto[i-1] || (hit[i] && (cnt > pla_pkg::CntW'(i)));
    end
  end

  assign any_hit = hit_upto[pla_pkg::MaxLights-1];
  assign cnt2    = cnt - {{(pla_pkg::CntW-1){1'b0}}, any_hit};
  assign add_ok  = cnt2 < pla_pkg::CntW'(pla_pkg::MaxLights);

  always_comb begin
    for (int i = 0; i < pla_pkg::MaxLights; i++) begin
      ctrl[i].shift = rotate || ((is_add || is_rem) && hit_upto[i]);
      ctrl[i].load  = is_add && add_ok && (cnt2 == pla_pkg::CntW'(i));
    end
  end

  for (genvar i = 0; i < pla_pkg::MaxLights; i++) begin : g_cell
    pla_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .neighbor (lamps[(i + 1) % pla_pkg::MaxLights]),
      .new_lamp (new_lamp),
      .px       (pos_x),
      .py       (pos_y),
      .pz       (pos_z),
      .lamp     (lamps[i]),
      .hit      (hit[i])
    );
  end

  assign sreq.go   = (state == ST_RUN) && present && !pend;
  assign sreq.init = acc && (op == pla_pkg::OP_QUERY) && lighting_enabled;

  pla_shade u_shade (
    .clk    (clk),
    .rst    (rst),
    .req    (sreq),
    .base_r (global_red),
    .base_g (global_green),
    .base_b (global_blue),
    .head   (lamps[0]),
    .qx     (qx),
    .qy     (qy),
    .qz     (qz),
    .ack    (sack),
    .dyn    (dyn),
    .r      (sr),
    .g      (sg),
    .b      (sb)
  );

  assign dint = dyn[20:8];
  assign tot  = {6'd0, ambient_level, 8'd0} + {1'b0, dyn};

  always_ff @(posedge clk) begin
    if (rst) begin
      lighting_enabled <= 1'b1;
      ambient_level    <= 8'd51;
      global_red       <= 8'd255;
      global_green     <= 8'd255;
      global_blue      <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pla_pkg::REG_ENABLE:  lighting_enabled <= cfg_data[0];
        pla_pkg::REG_AMBIENT: ambient_level    <= cfg_data;
        pla_pkg::REG_RED:     global_red       <= cfg_data;
        pla_pkg::REG_GREEN:   global_green     <= cfg_data;
        pla_pkg::REG_BLUE:    global_blue      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_FIN) ||
              (acc && !((op == pla_pkg::OP_QUERY) && lighting_enabled));
      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (op)
              pla_pkg::OP_ADD: begin
                if (add_ok) begin
                  cnt <= cnt2 + pla_pkg::CntW'(1);
                end
              end
              pla_pkg::OP_REMOVE: begin
                cnt <= cnt2;
              end
              pla_pkg::OP_CLEAR: begin
                cnt <= '0;
              end
              default: begin
                if (lighting_enabled) begin
                  state <= ST_RUN;
                  idx   <= '0;
                  pend  <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_RUN: begin
          if (rotate) begin
            pend <= 1'b0;
            idx  <= idx + pla_pkg::CntW'(1);
            if (idx == pla_pkg::CntW'(pla_pkg::MaxLights - 1)) begin
              state <= ST_FIN;
            end
          end else if (sreq.go) begin
            pend <= 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc) begin
      qx <= pos_x;
      qy <= pos_y;
      qz <= pos_z;
      if (op == pla_pkg::OP_QUERY) begin
        status       <= pla_pkg::STAT_QUERY;
        total_light  <= 8'd255;
        ambient_part <= 8'd255;
        dynamic_part <= '0;
        red          <= 8'd255;
        green        <= 8'd255;
        blue         <= 8'd255;
      end else begin
        status       <= (op == pla_pkg::OP_ADD && !add_ok) ? pla_pkg::STAT_FULL :
                                                             pla_pkg::STAT_OK;
        total_light  <= '0;
        ambient_part <= '0;
        dynamic_part <= '0;
        red          <= '0;
        green        <= '0;
        blue         <= '0;
      end
    end else if (state == ST_FIN) begin
      status       <= pla_pkg::STAT_QUERY;
      total_light  <= (tot[21:8] > 14'd255) ? 8'd255 : tot[15:8];
      ambient_part <= ambient_level;
      dynamic_part <= (dint > 13'd255) ? 8'd255 : dint[7:0];
      red          <= sr;
      green        <= sg;
      blue         <= sb;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= pla_pkg::CntW'(pla_pkg::MaxLights))
    else $error("light count above table size");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_query_runs: assert property (@(posedge clk) disable iff (rst)
    (acc && op == pla_pkg::OP_QUERY && lighting_enabled) |=> (busy && !done))
    else $error("lit query did not start the table walk");

  a_go_present: assert property (@(posedge clk) disable iff (rst)
    sreq.go |-> (idx < cnt && state == ST_RUN))
    else $error("shading started on an empty slot");

endmodule
